FILE: rtl/dpcb_pkg.sv
// shared constants and types for the disc pair contact and bounce pipeline
package dpcb_pkg;

  // square root unit: 130-bit radicand, one root bit per stage
  localparam int RAD_W       = 130;
  localparam int ROOT_W      = 65;
  localparam int REM_W       = ROOT_W + 1;
  localparam int SQRT_STAGES = ROOT_W;

  // divider unit: one quotient bit per stage after a range check stage
  localparam int NUM_W   = 114;
  localparam int DEN_W   = 82;
  localparam int QUO_W   = 33;
  localparam int DIV_LAT = QUO_W + 1;

  // front stages: differences, products, sums, partial products, merge, final
  localparam int PRE_STAGES = 6;
  localparam int BNC_DLY    = SQRT_STAGES + 1;
  localparam int PIPE_DEPTH = PRE_STAGES + SQRT_STAGES + 1 + DIV_LAT + 1;

  localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // divider result: quotient magnitude and a flag for quotient beyond QUO_W bits
  typedef struct packed {
    logic             big;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage

FILE: rtl/dpcb_sqrt.sv
// pipelined integer square root, one root bit per stage
module dpcb_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [dpcb_pkg::RAD_W-1:0]  rad,
  output logic [dpcb_pkg::ROOT_W-1:0] root
);
  import dpcb_pkg::*;

  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_q  [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_step
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W:0]    trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_rest
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
    end

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= {1'b0, trial};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j]  <= ge ? REM_W'(rem_sh - {1'b0, trial}) : REM_W'(rem_sh);
        root_q[j] <= {root_in[ROOT_W-2:0], ge};
        rad_q[j]  <= {rad_in[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[SQRT_STAGES-1];

endmodule

FILE: rtl/dpcb_div.sv
// pipelined unsigned restoring divider with a quotient range check
module dpcb_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [dpcb_pkg::NUM_W-1:0] num,
  input  logic [dpcb_pkg::DEN_W-1:0] den,
  output dpcb_pkg::div_res_t         res
);
  import dpcb_pkg::*;

  logic             big0;
  logic [DEN_W-1:0] rem0;
  logic [QUO_W-1:0] low0;
  logic [DEN_W-1:0] den0;

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic             big_q [QUO_W];

  // range check: quotient needs more than QUO_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      big0 <= {1'b0, num} >= {den, QUO_W'(0)};
      rem0 <= DEN_W'(num[NUM_W-1:QUO_W]);
      low0 <= num[QUO_W-1:0];
      den0 <= den;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic             big_in;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = rem0;
      assign low_in = low0;
      assign quo_in = '0;
      assign den_in = den0;
      assign big_in = big0;
    end else begin : g_rest
      assign rem_in = rem_q[j-1];
      assign low_in = low_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
      assign big_in = big_q[j-1];
    end

    // shift in the next dividend bit and subtract when it fits
    assign rem_sh = {rem_in, low_in[QUO_W-1]};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= ge ? DEN_W'(rem_sh - {1'b0, den_in}) : DEN_W'(rem_sh);
        low_q[j] <= {low_in[QUO_W-2:0], 1'b0};
        quo_q[j] <= {quo_in[QUO_W-2:0], ge};
        den_q[j] <= den_in;
        big_q[j] <= big_in;
      end
    end
  end

  assign res.big = big_q[QUO_W-1];
  assign res.quo = quo_q[QUO_W-1];

endmodule

FILE: rtl/disc_pair_contact_and_bounce_top.sv
// disc pair contact time and elastic bounce, fully pipelined
// throughput: one beat per cycle; the whole pipe advances unless the output beat is stalled
// depth is set by the 65-stage square root and the 34-stage contact time divider
// reset clears the valid bits only; payload registers are not reset
module disc_pair_contact_and_bounce_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] first_pos_x,
  input  logic signed [31:0] first_pos_y,
  input  logic signed [31:0] first_vel_x,
  input  logic signed [31:0] first_vel_y,
  input  logic        [30:0] first_rad,
  input  logic        [15:0] first_mass,
  input  logic signed [31:0] second_pos_x,
  input  logic signed [31:0] second_pos_y,
  input  logic signed [31:0] second_vel_x,
  input  logic signed [31:0] second_vel_y,
  input  logic        [30:0] second_rad,
  input  logic        [15:0] second_mass,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               will_touch,
  output logic signed [31:0] touch_time,
  output logic signed [31:0] first_new_vx,
  output logic signed [31:0] first_new_vy,
  output logic signed [31:0] second_new_vx,
  output logic signed [31:0] second_new_vy
);
  import dpcb_pkg::*;

  // velocity plus signed quotient magnitude, saturated to 32 bits
  function automatic logic [31:0] sat_add(logic [31:0] v, logic [QUO_W-1:0] mag,
                                          logic neg, logic big);
    logic [QUO_W+1:0] s;
    logic [QUO_W+1:0] m;
    m = {2'b00, mag};
    s = {{3{v[31]}}, v} + (neg ? -m : m);
    if (big) begin
      return neg ? SAT_NEG : SAT_POS;
    end
    if (s[QUO_W+1:31] == '0 || s[QUO_W+1:31] == '1) begin
      return s[31:0];
    end
    return s[QUO_W+1] ? SAT_NEG : SAT_POS;
  endfunction

  logic                  en;
  logic [PIPE_DEPTH-2:0] vld;

  // pipe advances unless a finished beat is held at the output
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[PIPE_DEPTH-3:0], in_valid};
      out_valid <= vld[PIPE_DEPTH-2];
    end
  end

  // stage 1: relative position, relative velocity, radius sum
  logic signed [32:0] s1_xx, s1_xy, s1_vx, s1_vy;
  logic [31:0]        s1_rsum;
  logic [15:0]        s1_m1, s1_m2;
  logic [3:0][31:0]   s1_vel;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_xx   <= {second_pos_x[31], second_pos_x} - {first_pos_x[31], first_pos_x};
      s1_xy   <= {second_pos_y[31], second_pos_y} - {first_pos_y[31], first_pos_y};
      s1_vx   <= {second_vel_x[31], second_vel_x} - {first_vel_x[31], first_vel_x};
      s1_vy   <= {second_vel_y[31], second_vel_y} - {first_vel_y[31], first_vel_y};
      s1_rsum <= {1'b0, first_rad} + {1'b0, second_rad};
      s1_m1   <= first_mass;
      s1_m2   <= second_mass;
      s1_vel  <= {second_vel_y, second_vel_x, first_vel_y, first_vel_x};
    end
  end

  // stage 2: component products
  logic signed [65:0] p_vxx, p_vyy, p_xvx, p_xyvy, p_xvy, p_xyvx, p_xxx, p_xyy;
  logic [63:0]        p_rr;
  logic [32:0]        xx_neg, xy_neg;

  assign p_vxx  = s1_vx * s1_vx;
  assign p_vyy  = s1_vy * s1_vy;
  assign p_xvx  = s1_xx * s1_vx;
  assign p_xyvy = s1_xy * s1_vy;
  assign p_xvy  = s1_xx * s1_vy;
  assign p_xyvx = s1_xy * s1_vx;
  assign p_xxx  = s1_xx * s1_xx;
  assign p_xyy  = s1_xy * s1_xy;
  assign p_rr   = s1_rsum * s1_rsum;
  assign xx_neg = -s1_xx;
  assign xy_neg = -s1_xy;

  logic [63:0]        s2_vxx, s2_vyy, s2_xxx, s2_xyy, s2_rr;
  logic signed [64:0] s2_xvx, s2_xyvy, s2_xvy, s2_xyvx;
  logic [16:0]        s2_msum, s2_m1d2, s2_m2d2;
  logic [31:0]        s2_axx, s2_axy;
  logic               s2_sxx, s2_sxy;
  logic [3:0][31:0]   s2_vel;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_vxx  <= p_vxx[63:0];
      s2_vyy  <= p_vyy[63:0];
      s2_xxx  <= p_xxx[63:0];
      s2_xyy  <= p_xyy[63:0];
      s2_rr   <= p_rr;
      s2_xvx  <= p_xvx[64:0];
      s2_xyvy <= p_xyvy[64:0];
      s2_xvy  <= p_xvy[64:0];
      s2_xyvx <= p_xyvx[64:0];
      s2_msum <= {1'b0, s1_m1} + {1'b0, s1_m2};
      s2_m1d2 <= {s1_m1, 1'b0};
      s2_m2d2 <= {s1_m2, 1'b0};
      s2_axx  <= s1_xx[32] ? xx_neg[31:0] : s1_xx[31:0];
      s2_axy  <= s1_xy[32] ? xy_neg[31:0] : s1_xy[31:0];
      s2_sxx  <= s1_xx[32];
      s2_sxy  <= s1_xy[32];
      s2_vel  <= s1_vel;
    end
  end

  // stage 3: dot and cross products
  logic [65:0] b_c, k_c, b_neg, k_neg;

  assign b_c   = {s2_xvx[64], s2_xvx} + {s2_xyvy[64], s2_xyvy};
  assign k_c   = {s2_xvy[64], s2_xvy} - {s2_xyvx[64], s2_xyvx};
  assign b_neg = -b_c;
  assign k_neg = -k_c;

  logic [64:0]        s3_a, s3_q, s3_kabs, s3_babs;
  logic signed [65:0] s3_b;
  logic               s3_bsgn, s3_sxx, s3_sxy;
  logic [63:0]        s3_rr;
  logic [16:0]        s3_msum, s3_m1d2, s3_m2d2;
  logic [31:0]        s3_axx, s3_axy;
  logic [3:0][31:0]   s3_vel;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a    <= {1'b0, s2_vxx} + {1'b0, s2_vyy};
      s3_q    <= {1'b0, s2_xxx} + {1'b0, s2_xyy};
      s3_b    <= b_c;
      s3_babs <= b_c[65] ? b_neg[64:0] : b_c[64:0];
      s3_bsgn <= b_c[65];
      s3_kabs <= k_c[65] ? k_neg[64:0] : k_c[64:0];
      s3_rr   <= s2_rr;
      s3_msum <= s2_msum;
      s3_m1d2 <= s2_m1d2;
      s3_m2d2 <= s2_m2d2;
      s3_axx  <= s2_axx;
      s3_axy  <= s2_axy;
      s3_sxx  <= s2_sxx;
      s3_sxy  <= s2_sxy;
      s3_vel  <= s2_vel;
    end
  end

  // stage 4: partial products of A*R^2 and K^2, bounce denominator and factors
  logic [67:0] p_all, p_kll;
  logic [63:0] p_alh;
  logic [64:0] p_ahl, p_klh;
  logic [60:0] p_ahh;
  logic [61:0] p_khh;
  logic [81:0] p_den, p_f1, p_f2;

  assign p_all = s3_a[33:0] * s3_rr[33:0];
  assign p_alh = s3_a[33:0] * s3_rr[63:34];
  assign p_ahl = s3_a[64:34] * s3_rr[33:0];
  assign p_ahh = s3_a[64:34] * s3_rr[63:34];
  assign p_kll = s3_kabs[33:0] * s3_kabs[33:0];
  assign p_klh = s3_kabs[33:0] * s3_kabs[64:34];
  assign p_khh = s3_kabs[64:34] * s3_kabs[64:34];
  assign p_den = s3_q * s3_msum;
  assign p_f1  = s3_babs * s3_m2d2;
  assign p_f2  = s3_babs * s3_m1d2;

  logic [67:0]        s4_all, s4_kll;
  logic [63:0]        s4_alh;
  logic [64:0]        s4_ahl, s4_klh;
  logic [60:0]        s4_ahh;
  logic [61:0]        s4_khh;
  logic [81:0]        s4_den, s4_f1, s4_f2;
  logic [31:0]        s4_axx, s4_axy;
  logic [64:0]        s4_a;
  logic signed [65:0] s4_b;
  logic               s4_anz, s4_pass;
  logic [3:0]         s4_neg;
  logic [3:0][31:0]   s4_vel;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_all  <= p_all;
      s4_alh  <= p_alh;
      s4_ahl  <= p_ahl;
      s4_ahh  <= p_ahh;
      s4_kll  <= p_kll;
      s4_klh  <= p_klh;
      s4_khh  <= p_khh;
      s4_den  <= p_den;
      s4_f1   <= p_f1;
      s4_f2   <= p_f2;
      s4_axx  <= s3_axx;
      s4_axy  <= s3_axy;
      s4_a    <= s3_a;
      s4_b    <= s3_b;
      s4_anz  <= s3_a != '0;
      s4_pass <= (s3_q == '0) || (s3_msum == '0);
      // delta sign per output: first disc adds, second disc subtracts
      s4_neg  <= {~(s3_bsgn ^ s3_sxy), ~(s3_bsgn ^ s3_sxx),
                  s3_bsgn ^ s3_sxy, s3_bsgn ^ s3_sxx};
      s4_vel  <= s3_vel;
    end
  end

  // stage 5: merge partial products, split bounce numerators
  logic [128:0] arr_c;
  logic [129:0] kk_c;
  logic [63:0]  np0_c [4];
  logic [63:0]  np1_c [4];
  logic [49:0]  np2_c [4];

  assign arr_c = 129'(s4_all) + (129'(s4_alh) << 34) + (129'(s4_ahl) << 34)
               + (129'(s4_ahh) << 68);
  assign kk_c  = 130'(s4_kll) + (130'(s4_klh) << 35) + (130'(s4_khh) << 68);

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      np0_c[n] = (n < 2 ? s4_f1[31:0] : s4_f2[31:0])
               * (((n & 1) != 0) ? s4_axy : s4_axx);
      np1_c[n] = (n < 2 ? s4_f1[63:32] : s4_f2[63:32])
               * (((n & 1) != 0) ? s4_axy : s4_axx);
      np2_c[n] = (n < 2 ? s4_f1[81:64] : s4_f2[81:64])
               * (((n & 1) != 0) ? s4_axy : s4_axx);
    end
  end

  logic [128:0]       s5_arr;
  logic [129:0]       s5_kk;
  logic [63:0]        s5_np0 [4];
  logic [63:0]        s5_np1 [4];
  logic [49:0]        s5_np2 [4];
  logic [81:0]        s5_den;
  logic [64:0]        s5_a;
  logic signed [65:0] s5_b;
  logic               s5_anz, s5_pass;
  logic [3:0]         s5_neg;
  logic [3:0][31:0]   s5_vel;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_arr  <= arr_c;
      s5_kk   <= kk_c;
      s5_np0  <= np0_c;
      s5_np1  <= np1_c;
      s5_np2  <= np2_c;
      s5_den  <= s4_den;
      s5_a    <= s4_a;
      s5_b    <= s4_b;
      s5_anz  <= s4_anz;
      s5_pass <= s4_pass;
      s5_neg  <= s4_neg;
      s5_vel  <= s4_vel;
    end
  end

  // stage 6: quarter discriminant and full bounce numerators
  logic [130:0]     d_c;
  logic [NUM_W-1:0] num_c [4];

  assign d_c = {2'b00, s5_arr} - {1'b0, s5_kk};

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      num_c[n] = NUM_W'(s5_np0[n]) + (NUM_W'(s5_np1[n]) << 32) + (NUM_W'(s5_np2[n]) << 64);
    end
  end

  logic [RAD_W-1:0]   s6_rad;
  logic               s6_ok;
  logic [NUM_W-1:0]   s6_num [4];
  logic [DEN_W-1:0]   s6_den;
  logic [64:0]        s6_a;
  logic signed [65:0] s6_b;
  logic               s6_pass;
  logic [3:0]         s6_neg;
  logic [3:0][31:0]   s6_vel;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_rad  <= d_c[RAD_W-1:0];
      s6_ok   <= s5_anz && !d_c[130] && (d_c != '0);
      s6_num  <= num_c;
      s6_den  <= s5_den;
      s6_a    <= s5_a;
      s6_b    <= s5_b;
      s6_pass <= s5_pass;
      s6_neg  <= s5_neg;
      s6_vel  <= s5_vel;
    end
  end

  // contact path: square root of the quarter discriminant
  logic [ROOT_W-1:0] root;

  dpcb_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s6_rad),
    .root (root)
  );

  // A, B and the contact flag ride alongside the square root
  logic [64:0]        sd_a  [SQRT_STAGES];
  logic signed [65:0] sd_b  [SQRT_STAGES];
  logic               sd_ok [SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_a[0]  <= s6_a;
      sd_b[0]  <= s6_b;
      sd_ok[0] <= s6_ok;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        sd_a[i]  <= sd_a[i-1];
        sd_b[i]  <= sd_b[i-1];
        sd_ok[i] <= sd_ok[i-1];
      end
    end
  end

  // earlier root unless it lies in the past, then the later root
  logic signed [67:0] nb_c, n1_c, n2_c, n_c, nn_c;

  assign nb_c = -{{2{sd_b[SQRT_STAGES-1][65]}}, sd_b[SQRT_STAGES-1]};
  assign n1_c = nb_c - {3'b000, root};
  assign n2_c = nb_c + {3'b000, root};
  assign n_c  = n1_c[67] ? n2_c : n1_c;
  assign nn_c = -n_c;

  logic [66:0] s7_nmag;
  logic        s7_nneg;
  logic [64:0] s7_a;
  logic        s7_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_nmag <= n_c[67] ? nn_c[66:0] : n_c[66:0];
      s7_nneg <= n_c[67];
      s7_a    <= sd_a[SQRT_STAGES-1];
      s7_ok   <= sd_ok[SQRT_STAGES-1];
    end
  end

  // contact time divider: (|N| * 2^16) / A
  div_res_t tres;

  dpcb_div u_div_time (
    .clk (clk),
    .en  (en),
    .num ({31'b0, s7_nmag, 16'b0}),
    .den ({17'b0, s7_a}),
    .res (tres)
  );

  logic td_nneg [DIV_LAT];
  logic td_ok   [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      td_nneg[0] <= s7_nneg;
      td_ok[0]   <= s7_ok;
      for (int i = 1; i < DIV_LAT; i++) begin
        td_nneg[i] <= td_nneg[i-1];
        td_ok[i]   <= td_ok[i-1];
      end
    end
  end

  // contact time sign and saturation
  logic        t_sat;
  logic [31:0] t_mag, t_neg, time_c;

  assign t_sat  = tres.big || (tres.quo[QUO_W-1:31] != '0);
  assign t_mag  = {1'b0, tres.quo[30:0]};
  assign t_neg  = -t_mag;
  assign time_c = !td_ok[DIV_LAT-1] ? '0 :
                  t_sat ? (td_nneg[DIV_LAT-1] ? SAT_NEG : SAT_POS) :
                  (td_nneg[DIV_LAT-1] ? t_neg : t_mag);

  // bounce path: one divider per velocity component
  div_res_t bres [4];

  for (genvar n = 0; n < 4; n++) begin : g_bdiv
    dpcb_div u_div_bnc (
      .clk (clk),
      .en  (en),
      .num (s6_num[n]),
      .den (s6_den),
      .res (bres[n])
    );
  end

  logic [3:0][31:0] bd_vel  [DIV_LAT];
  logic [3:0]       bd_neg  [DIV_LAT];
  logic             bd_pass [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      bd_vel[0]  <= s6_vel;
      bd_neg[0]  <= s6_neg;
      bd_pass[0] <= s6_pass;
      for (int i = 1; i < DIV_LAT; i++) begin
        bd_vel[i]  <= bd_vel[i-1];
        bd_neg[i]  <= bd_neg[i-1];
        bd_pass[i] <= bd_pass[i-1];
      end
    end
  end

  // new velocities; coincident centres or zero total mass pass through
  logic [3:0][31:0] bnc_c;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      bnc_c[n] = bd_pass[DIV_LAT-1] ? bd_vel[DIV_LAT-1][n] :
                 sat_add(bd_vel[DIV_LAT-1][n], bres[n].quo, bd_neg[DIV_LAT-1][n],
                         bres[n].big);
    end
  end

  // hold bounce results until the contact time catches up
  logic [3:0][31:0] bv [BNC_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      bv[0] <= bnc_c;
      for (int i = 1; i < BNC_DLY; i++) begin
        bv[i] <= bv[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      will_touch    <= td_ok[DIV_LAT-1];
      touch_time    <= time_c;
      first_new_vx  <= bv[BNC_DLY-1][0];
      first_new_vy  <= bv[BNC_DLY-1][1];
      second_new_vx <= bv[BNC_DLY-1][2];
      second_new_vy <= bv[BNC_DLY-1][3];
    end
  end

`ifndef SYNTH
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid right after reset");

  a_no_touch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !will_touch |-> touch_time == '0)
    else $error("contact time nonzero without contact");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(vld))
    else $error("pipeline valid bits moved while stalled");
`endif

endmodule
